// ===== sv/lcta_pkg.sv =====
// Shared constants, register codes and types of the load-cell tare and scale block.
package lcta_pkg;

   localparam int SAMPLE_BITS_DEF = 24;
   localparam int QUEUE_DEPTH_DEF = 2;

   localparam int VALUE_BITS     = 25;
   localparam int CAL_BITS       = 24;
   localparam int COUNT_BITS     = 8;
   localparam int CSR_INDEX_BITS = 2;
   localparam int CSR_DATA_BITS  = 24;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_WEIGH_SAMPLES = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_TARE_SAMPLES  = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_CAL_DIVISOR   = 2'd2;

   localparam logic [COUNT_BITS-1:0] WEIGH_SAMPLES_RST = 8'd10;
   localparam logic [COUNT_BITS-1:0] TARE_SAMPLES_RST  = 8'd20;
   localparam logic [CAL_BITS-1:0]   CAL_DIVISOR_RST   = 24'd1000;

   localparam logic KIND_WEIGH = 1'b0;
   localparam logic KIND_TARE  = 1'b1;

   typedef struct packed {
      logic busy;
      logic done;
   } div_stat_type;

endpackage

// ===== sv/lcta_fifo.sv =====
// Short queue of completed runs between the sample front end and the result back end.
module lcta_fifo #(
   parameter int WIDTH = 42,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] wdata,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] rdata,
   output logic             empty
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [PW-1:0]    wr_ptr_ff;
   logic [PW-1:0]    rd_ptr_ff;
   logic [CW-1:0]    fill_ff;
   logic             do_push;
   logic             do_pop;

   assign full    = (fill_ff == CW'(DEPTH));
   assign empty   = (fill_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign rdata   = mem[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + PW'(1);
         end
         if (do_pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + PW'(1);
         end
         if (do_push && !do_pop) begin
            fill_ff <= fill_ff + CW'(1);
         end else if (do_pop && !do_push) begin
            fill_ff <= fill_ff - CW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem[wr_ptr_ff] <= wdata;
      end
   end

endmodule

// ===== sv/lcta_front.sv =====
// Sample front end: accumulates runs of one kind and queues each completed run.
module lcta_front #(
   parameter int SAMPLE_BITS = lcta_pkg::SAMPLE_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic                                req_cmd,
   input  logic signed [SAMPLE_BITS-1:0]       req_sample,
   input  logic [lcta_pkg::COUNT_BITS-1:0]     weigh_samples,
   input  logic [lcta_pkg::COUNT_BITS-1:0]     tare_samples,
   input  logic                                q_full,
   output logic                                q_push,
   output logic [SAMPLE_BITS+lcta_pkg::COUNT_BITS+9:0] q_wdata
);

   localparam int SW = SAMPLE_BITS + lcta_pkg::COUNT_BITS;
   localparam int NW = lcta_pkg::COUNT_BITS;

   logic [SW-1:0] run_sum_ff;
   logic [NW-1:0] run_count_ff;
   logic          run_kind_ff;

   logic          accept;
   logic          same;
   logic [SW-1:0] sum_in;
   logic [NW-1:0] count_in;
   logic [NW-1:0] target;
   logic [NW-1:0] target_eff;
   logic          run_done;

   always_comb begin
      accept     = req_valid && !q_full;
      same       = (req_cmd == run_kind_ff);
      sum_in     = (same ? run_sum_ff : '0)
                 + {{(SW - SAMPLE_BITS){req_sample[SAMPLE_BITS-1]}}, req_sample};
      count_in   = (same ? run_count_ff : '0) + NW'(1);
      target     = (req_cmd == lcta_pkg::KIND_TARE) ? tare_samples : weigh_samples;
      target_eff = (target == '0) ? NW'(1) : target;
      run_done   = (count_in >= target_eff) || (count_in == '0);
      q_push     = accept && run_done;
      q_wdata    = {req_cmd, (count_in == '0), count_in, sum_in};
   end

   assign req_ready = !q_full;

   always_ff @(posedge clock) begin
      if (reset) begin
         run_sum_ff   <= '0;
         run_count_ff <= '0;
         run_kind_ff  <= lcta_pkg::KIND_WEIGH;
      end else if (accept) begin
         run_kind_ff <= req_cmd;
         if (run_done) begin
            run_sum_ff   <= '0;
            run_count_ff <= '0;
         end else begin
            run_sum_ff   <= sum_in;
            run_count_ff <= count_in;
         end
      end
   end

endmodule

// ===== sv/lcta_div.sv =====
// Shared unsigned restoring divider, two quotient bits per cycle.
module lcta_div #(
   parameter int DIV_BITS = 32,
   parameter int DEN_BITS = 24
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  logic [DIV_BITS-1:0]    dividend,
   input  logic [DEN_BITS-1:0]    divisor,
   output lcta_pkg::div_stat_type stat,
   output logic [DIV_BITS-1:0]    quotient,
   output logic [DEN_BITS-1:0]    remainder
);

   localparam int STEPS = DIV_BITS / 2;
   localparam int CW    = $clog2(STEPS + 1);

   logic [DIV_BITS-1:0] quo_ff;
   logic [DEN_BITS-1:0] rem_ff;
   logic [DEN_BITS-1:0] den_ff;
   logic [CW-1:0]       cnt_ff;
   logic                busy_ff;
   logic                done_ff;

   logic [DEN_BITS:0]   t1;
   logic [DEN_BITS:0]   t2;
   logic [DEN_BITS:0]   d1;
   logic [DEN_BITS:0]   d2;
   logic                ge1;
   logic                ge2;
   logic [DEN_BITS-1:0] r1;
   logic [DEN_BITS-1:0] r2;

   always_comb begin
      t1  = {rem_ff, quo_ff[DIV_BITS-1]};
      d1  = t1 - {1'b0, den_ff};
      ge1 = (t1 >= {1'b0, den_ff});
      r1  = ge1 ? d1[DEN_BITS-1:0] : t1[DEN_BITS-1:0];
      t2  = {r1, quo_ff[DIV_BITS-2]};
      d2  = t2 - {1'b0, den_ff};
      ge2 = (t2 >= {1'b0, den_ff});
      r2  = ge2 ? d2[DEN_BITS-1:0] : t2[DEN_BITS-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= CW'(STEPS);
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - CW'(1);
            if (cnt_ff == CW'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         quo_ff <= dividend;
         rem_ff <= '0;
         den_ff <= divisor;
      end else if (busy_ff) begin
         quo_ff <= {quo_ff[DIV_BITS-3:0], ge1, ge2};
         rem_ff <= r2;
      end
   end

   assign stat.busy = busy_ff;
   assign stat.done = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

endmodule

// ===== sv/lcta_back.sv =====
// Result back end: averages a queued run, applies tare and calibration, rounds and saturates.
module lcta_back #(
   parameter int SAMPLE_BITS = lcta_pkg::SAMPLE_BITS_DEF
) (
   input  logic                                      clock,
   input  logic                                      reset,
   input  logic                                      q_empty,
   input  logic [SAMPLE_BITS+lcta_pkg::COUNT_BITS+9:0] q_rdata,
   output logic                                      q_pop,
   input  logic [lcta_pkg::CAL_BITS-1:0]             cal_divisor,
   output logic                                      div_start,
   output logic [((SAMPLE_BITS+9)/2)*2-1:0]          div_dividend,
   output logic [lcta_pkg::CAL_BITS-1:0]             div_divisor,
   input  lcta_pkg::div_stat_type                    div_stat,
   input  logic [((SAMPLE_BITS+9)/2)*2-1:0]          div_quotient,
   input  logic [lcta_pkg::CAL_BITS-1:0]             div_remainder,
   output logic                                      rsp_valid,
   input  logic                                      rsp_ready,
   output logic                                      rsp_kind,
   output logic signed [lcta_pkg::VALUE_BITS-1:0]    rsp_value
);

   localparam int SB = SAMPLE_BITS;
   localparam int SW = SAMPLE_BITS + lcta_pkg::COUNT_BITS;
   localparam int NB = ((SAMPLE_BITS + 9) / 2) * 2;
   localparam int VW = lcta_pkg::VALUE_BITS;
   localparam int DW = lcta_pkg::CAL_BITS;
   localparam int NW = lcta_pkg::COUNT_BITS;

   localparam logic [VW-1:0] VALUE_MAX = {1'b0, {(VW - 1){1'b1}}};
   localparam logic [VW-1:0] VALUE_MIN = {1'b1, {(VW - 1){1'b0}}};

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_AVG  = 3'd1;
   localparam logic [2:0] S_NET  = 3'd2;
   localparam logic [2:0] S_CAL  = 3'd3;
   localparam logic [2:0] S_OUT  = 3'd4;

   logic [2:0]    state_ff;
   logic [2:0]    state_in;
   logic          kind_ff;
   logic          neg_ff;
   logic [SB-1:0] avg_ff;
   logic [SB-1:0] offset_ff;
   logic [NB-1:0] mag_ff;
   logic          rsp_valid_ff;
   logic          rsp_kind_ff;
   logic [VW-1:0] rsp_value_ff;

   logic [SW-1:0] job_sum;
   logic [NW:0]   job_count;
   logic          job_kind;
   logic [SW-1:0] abs_sum;
   logic [SB-1:0] quo_lo;
   logic [SB-1:0] avg_s;
   logic [SB:0]   net;
   logic [SB:0]   abs_net;
   logic [DW-1:0] cal_eff;
   logic          rnd_up;
   logic [NB:0]   mag_x;
   logic          over_pos;
   logic          over_neg;
   logic [VW-1:0] sat_value;
   logic          load_rsp;

   always_comb begin
      job_sum   = q_rdata[SW-1:0];
      job_count = q_rdata[SW+NW:SW];
      job_kind  = q_rdata[SW+NW+1];
      abs_sum   = job_sum[SW-1] ? (~job_sum + SW'(1)) : job_sum;
      quo_lo    = div_quotient[SB-1:0];
      avg_s     = neg_ff ? (~quo_lo + SB'(1)) : quo_lo;
      net       = {avg_ff[SB-1], avg_ff} - {offset_ff[SB-1], offset_ff};
      abs_net   = net[SB] ? (~net + (SB + 1)'(1)) : net;
      cal_eff   = (cal_divisor == '0) ? DW'(1) : cal_divisor;
      rnd_up    = ({div_remainder, 1'b0} >= {1'b0, cal_eff});
      mag_x     = {1'b0, mag_ff};
      over_pos  = (mag_x > (NB + 1)'(VALUE_MAX));
      over_neg  = (mag_x > (NB + 1)'(VALUE_MIN));
      if (neg_ff) begin
         sat_value = over_neg ? VALUE_MIN : (~mag_x[VW-1:0] + VW'(1));
      end else begin
         sat_value = over_pos ? VALUE_MAX : mag_x[VW-1:0];
      end
   end

   always_comb begin
      state_in     = state_ff;
      q_pop        = 1'b0;
      div_start    = 1'b0;
      load_rsp     = 1'b0;
      div_dividend = NB'(abs_sum);
      div_divisor  = DW'(job_count);
      case (state_ff)
         S_IDLE: begin
            if (!q_empty) begin
               q_pop     = 1'b1;
               div_start = 1'b1;
               state_in  = S_AVG;
            end
         end
         S_AVG: begin
            if (div_stat.done) begin
               state_in = (kind_ff == lcta_pkg::KIND_TARE) ? S_OUT : S_NET;
            end
         end
         S_NET: begin
            div_start    = 1'b1;
            div_dividend = NB'(abs_net);
            div_divisor  = cal_eff;
            state_in     = S_CAL;
         end
         S_CAL: begin
            if (div_stat.done) begin
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               load_rsp = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         offset_ff    <= '0;
      end else begin
         state_ff <= state_in;
         if (load_rsp) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (state_ff == S_AVG && div_stat.done && kind_ff == lcta_pkg::KIND_TARE) begin
            offset_ff <= avg_s;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         kind_ff <= job_kind;
         neg_ff  <= job_sum[SW-1];
      end
      if (state_ff == S_AVG && div_stat.done) begin
         avg_ff <= avg_s;
         mag_ff <= div_quotient;
      end
      if (state_ff == S_NET) begin
         neg_ff <= net[SB];
      end
      if (state_ff == S_CAL && div_stat.done) begin
         mag_ff <= div_quotient + NB'(rnd_up);
      end
      if (load_rsp) begin
         rsp_kind_ff  <= kind_ff;
         rsp_value_ff <= sat_value;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_kind  = rsp_kind_ff;
   assign rsp_value = rsp_value_ff;

`ifndef SYNTH
   a_start_idle_div: assert property (@(posedge clock) disable iff (reset)
      div_start |-> !div_stat.busy)
      else $error("divider started while busy");

   a_done_in_wait: assert property (@(posedge clock) disable iff (reset)
      div_stat.done |-> (state_ff == S_AVG || state_ff == S_CAL))
      else $error("divider finished outside a wait state");

   a_pop_starts_avg: assert property (@(posedge clock) disable iff (reset)
      q_pop |=> (state_ff == S_AVG && div_stat.busy))
      else $error("popped run did not start averaging");
`endif

endmodule

// ===== sv/load_cell_tare_average_scale.sv =====
// Load-cell tare and scale block: configuration registers, front end, run queue and back end.
// Samples tagged weigh or tare are accepted one per cycle while the run queue has room; a run
// of one kind is summed and a change of kind restarts it. Each completed run gives one result:
// a tare run stores its truncated average as the zero offset and reports it, a weigh run
// reports (average - offset) / cal_divisor rounded half away from zero, saturated to 25 bits.
// The back end makes two passes through the shared divider for a weight result, and the
// divider retires two quotient bits per cycle; a tare result takes one pass. The back end
// waits while the output stalls, and pops the next queued run only after loading the last
// result. A queue of QUEUE_DEPTH completed runs lets the front end keep taking samples
// meanwhile. Register writes are accepted every cycle.
module load_cell_tare_average_scale #(
   parameter int SAMPLE_BITS = lcta_pkg::SAMPLE_BITS_DEF,
   parameter int QUEUE_DEPTH = lcta_pkg::QUEUE_DEPTH_DEF
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic [lcta_pkg::CSR_INDEX_BITS-1:0]    csr_index,
   input  logic [lcta_pkg::CSR_DATA_BITS-1:0]     csr_data,
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  logic                                   req_cmd,
   input  logic signed [SAMPLE_BITS-1:0]          req_sample,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic                                   rsp_kind,
   output logic signed [lcta_pkg::VALUE_BITS-1:0] rsp_value
);

   localparam int JW = SAMPLE_BITS + lcta_pkg::COUNT_BITS + 10;
   localparam int NB = ((SAMPLE_BITS + 9) / 2) * 2;
   localparam int NW = lcta_pkg::COUNT_BITS;
   localparam int DW = lcta_pkg::CAL_BITS;

   logic [NW-1:0] weigh_samples_ff;
   logic [NW-1:0] tare_samples_ff;
   logic [DW-1:0] cal_divisor_ff;

   logic          q_push;
   logic [JW-1:0] q_wdata;
   logic          q_full;
   logic          q_pop;
   logic [JW-1:0] q_rdata;
   logic          q_empty;

   logic                   div_start;
   logic [NB-1:0]          div_dividend;
   logic [DW-1:0]          div_divisor;
   lcta_pkg::div_stat_type div_stat;
   logic [NB-1:0]          div_quotient;
   logic [DW-1:0]          div_remainder;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         weigh_samples_ff <= lcta_pkg::WEIGH_SAMPLES_RST;
         tare_samples_ff  <= lcta_pkg::TARE_SAMPLES_RST;
         cal_divisor_ff   <= lcta_pkg::CAL_DIVISOR_RST;
      end else if (csr_valid) begin
         case (csr_index)
            lcta_pkg::CSR_WEIGH_SAMPLES: begin
               weigh_samples_ff <= csr_data[NW-1:0];
            end
            lcta_pkg::CSR_TARE_SAMPLES: begin
               tare_samples_ff <= csr_data[NW-1:0];
            end
            lcta_pkg::CSR_CAL_DIVISOR: begin
               cal_divisor_ff <= csr_data[DW-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   lcta_front #(
      .SAMPLE_BITS(SAMPLE_BITS)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_cmd      (req_cmd),
      .req_sample   (req_sample),
      .weigh_samples(weigh_samples_ff),
      .tare_samples (tare_samples_ff),
      .q_full       (q_full),
      .q_push       (q_push),
      .q_wdata      (q_wdata)
   );

   lcta_fifo #(
      .WIDTH(JW),
      .DEPTH(QUEUE_DEPTH)
   ) u_fifo (
      .clock(clock),
      .reset(reset),
      .push (q_push),
      .wdata(q_wdata),
      .full (q_full),
      .pop  (q_pop),
      .rdata(q_rdata),
      .empty(q_empty)
   );

   lcta_div #(
      .DIV_BITS(NB),
      .DEN_BITS(DW)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .stat     (div_stat),
      .quotient (div_quotient),
      .remainder(div_remainder)
   );

   lcta_back #(
      .SAMPLE_BITS(SAMPLE_BITS)
   ) u_back (
      .clock        (clock),
      .reset        (reset),
      .q_empty      (q_empty),
      .q_rdata      (q_rdata),
      .q_pop        (q_pop),
      .cal_divisor  (cal_divisor_ff),
      .div_start    (div_start),
      .div_dividend (div_dividend),
      .div_divisor  (div_divisor),
      .div_stat     (div_stat),
      .div_quotient (div_quotient),
      .div_remainder(div_remainder),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_kind     (rsp_kind),
      .rsp_value    (rsp_value)
   );

endmodule

// ===== test/load_cell_tare_average_scale_tb.sv =====
// Testbench for load_cell_tare_average_scale: directed and random sample runs checked by a predictor.
`timescale 1ns / 1ps
module load_cell_tare_average_scale_tb;

   localparam int SB = lcta_pkg::SAMPLE_BITS_DEF;
   localparam int VB = lcta_pkg::VALUE_BITS;
   localparam logic [lcta_pkg::CSR_INDEX_BITS-1:0] CSR_UNUSED = 2'd3;
   localparam int IDLE_LIMIT = 5000;
   localparam int SETTLE_CYCLES = 80;
   localparam int HOLD_CYCLES = 400;
   localparam longint VALUE_HI = (longint'(1) << (VB - 1)) - 1;
   localparam longint VALUE_LO = -(longint'(1) << (VB - 1));
   localparam logic signed [SB-1:0] SAMPLE_MAX = {1'b0, {(SB-1){1'b1}}};
   localparam logic signed [SB-1:0] SAMPLE_MIN = {1'b1, {(SB-1){1'b0}}};

   typedef struct {
      logic                   cmd;
      logic signed [SB-1:0]   sample;
   } sample_item_type;

   typedef struct {
      logic                   kind;
      logic signed [VB-1:0]   value;
   } reading_type;

   logic                                  clock = 1'b0;
   logic                                  reset = 1'b1;
   logic                                  csr_valid = 1'b0;
   logic                                  csr_ready;
   logic [lcta_pkg::CSR_INDEX_BITS-1:0]   csr_index = '0;
   logic [lcta_pkg::CSR_DATA_BITS-1:0]    csr_data = '0;
   logic                                  req_valid = 1'b0;
   logic                                  req_ready;
   logic                                  req_cmd = lcta_pkg::KIND_WEIGH;
   logic signed [SB-1:0]                  req_sample = '0;
   logic                                  rsp_valid;
   logic                                  rsp_ready = 1'b0;
   logic                                  rsp_kind;
   logic signed [VB-1:0]                  rsp_value;

   logic [lcta_pkg::COUNT_BITS-1:0]  cfg_weigh = lcta_pkg::WEIGH_SAMPLES_RST;
   logic [lcta_pkg::COUNT_BITS-1:0]  cfg_tare = lcta_pkg::TARE_SAMPLES_RST;
   logic [lcta_pkg::CAL_BITS-1:0]    cfg_div = lcta_pkg::CAL_DIVISOR_RST;
   longint                           run_sum = 0;
   logic [lcta_pkg::COUNT_BITS-1:0]  run_count = '0;
   logic                             run_kind = lcta_pkg::KIND_WEIGH;
   longint                           zero_offset = 0;

   sample_item_type  sample_queue[$];
   reading_type      readings_due[$];
   sample_item_type  next_item;
   reading_type      due_reading;

   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   int hold_token = 0;
   int hold_seen = 0;
   int hold_left = 0;
   int items_taken = 0;
   int readings_seen = 0;
   int mismatches = 0;
   int idle_cycles = 0;
   int phases = 0;

   load_cell_tare_average_scale #(.SAMPLE_BITS(SB)) dut (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_cmd    (req_cmd),
      .req_sample (req_sample),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_kind   (rsp_kind),
      .rsp_value  (rsp_value)
   );

   always #4 clock = ~clock;

   function automatic longint clamp_value(longint v);
      if (v > VALUE_HI) return VALUE_HI;
      if (v < VALUE_LO) return VALUE_LO;
      return v;
   endfunction

   function automatic void predict_reading(logic cmd, logic signed [SB-1:0] sample);
      int               target;
      int               span;
      longint           avg;
      longint           net;
      longint unsigned  mag;
      longint unsigned  d;
      longint unsigned  q;
      reading_type      r;
      if (cmd != run_kind) begin
         run_kind = cmd;
         run_sum = 0;
         run_count = '0;
      end
      run_sum = run_sum + longint'(sample);
      run_count = run_count + 1'b1;
      target = (cmd == lcta_pkg::KIND_TARE) ? int'(cfg_tare) : int'(cfg_weigh);
      if (target == 0) target = 1;
      if (int'(run_count) < target && run_count != 0) return;
      span = (run_count == 0) ? 256 : int'(run_count);
      avg = run_sum / span;
      run_sum = 0;
      run_count = '0;
      r.kind = cmd;
      if (cmd == lcta_pkg::KIND_TARE) begin
         zero_offset = avg;
         r.value = VB'(clamp_value(avg));
      end else begin
         net = avg - zero_offset;
         d = (cfg_div == 0) ? 1 : cfg_div;
         mag = (net < 0) ? -net : net;
         q = (2 * mag + d) / (2 * d);
         r.value = VB'(clamp_value((net < 0) ? -longint'(q) : longint'(q)));
      end
      readings_due.push_back(r);
   endfunction

   function automatic logic signed [SB-1:0] pick_sample();
      int                     r;
      logic signed [SB-1:0]   v;
      r = $urandom_range(99);
      if (r < 4) return SAMPLE_MAX;
      if (r < 8) return SAMPLE_MIN;
      if (r < 10) return (r == 8) ? '0 : '1;
      if (r < 35) v = SB'(int'($urandom_range(0, 8000)) - 4000);
      else v = SB'($urandom);
      return v;
   endfunction

   function automatic void push_sample(logic cmd, logic signed [SB-1:0] s);
      sample_item_type it;
      it.cmd = cmd;
      it.sample = s;
      sample_queue.push_back(it);
   endfunction

   function automatic void random_runs(int count, int tare_pct);
      int   pushed;
      int   r;
      int   len;
      int   tgt;
      logic cmd;
      pushed = 0;
      while (pushed < count) begin
         r = $urandom_range(99);
         cmd = ($urandom_range(99) < tare_pct) ? lcta_pkg::KIND_TARE : lcta_pkg::KIND_WEIGH;
         tgt = (cmd == lcta_pkg::KIND_TARE) ? int'(cfg_tare) : int'(cfg_weigh);
         if (tgt == 0) tgt = 1;
         if (r < 80) len = tgt;
         else if (r < 92) len = (tgt > 1) ? int'($urandom_range(1, tgt - 1)) : 1;
         else len = 1;
         if (len > count - pushed) len = count - pushed;
         repeat (len) push_sample(cmd, pick_sample());
         pushed += len;
      end
   endfunction

   task automatic write_reg(logic [lcta_pkg::CSR_INDEX_BITS-1:0] idx,
                            logic [lcta_pkg::CSR_DATA_BITS-1:0] data);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= data;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         lcta_pkg::CSR_WEIGH_SAMPLES: cfg_weigh = data[lcta_pkg::COUNT_BITS-1:0];
         lcta_pkg::CSR_TARE_SAMPLES:  cfg_tare = data[lcta_pkg::COUNT_BITS-1:0];
         lcta_pkg::CSR_CAL_DIVISOR:   cfg_div = data[lcta_pkg::CAL_BITS-1:0];
         default: ;
      endcase
   endtask

   task automatic settle();
      do @(negedge clock);
      while (sample_queue.size() != 0 || req_valid || readings_due.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_phase(int weigh, int tare, int div, int send_pct, int recv_pct);
      write_reg(lcta_pkg::CSR_WEIGH_SAMPLES, {16'($urandom), 8'(weigh)});
      write_reg(lcta_pkg::CSR_TARE_SAMPLES, {16'($urandom), 8'(tare)});
      write_reg(lcta_pkg::CSR_CAL_DIVISOR, 24'(div));
      write_reg(CSR_UNUSED, 24'($urandom));
      send_idle_pct = send_pct;
      recv_stall_pct = recv_pct;
      phases++;
   endtask

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            predict_reading(req_cmd, req_sample);
            items_taken++;
         end
         if (!req_valid || req_ready) begin
            if (sample_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               next_item = sample_queue.pop_front();
               req_valid <= 1'b1;
               req_cmd <= next_item.cmd;
               req_sample <= next_item.sample;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            readings_seen++;
            if (readings_due.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("unexpected reading %0d: kind %0d value %0d",
                           readings_seen, rsp_kind, rsp_value);
            end else begin
               due_reading = readings_due.pop_front();
               if (rsp_kind !== due_reading.kind || rsp_value !== due_reading.value) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("reading %0d: expected kind %0d value %0d, got kind %0d value %0d",
                              readings_seen, due_reading.kind, due_reading.value,
                              rsp_kind, rsp_value);
               end
            end
         end
         if (hold_token != hold_seen) begin
            hold_seen = hold_token;
            hold_left = HOLD_CYCLES;
            rsp_ready <= 1'b0;
         end else if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         idle_cycles <= 0;
      end else if ((req_valid && req_ready) || (rsp_valid && rsp_ready)
                   || (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("load_cell_tare_average_scale_tb NOT OK");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // reset configuration: one weigh run rounding a half up
      repeat (10) push_sample(lcta_pkg::KIND_WEIGH, 24'sd1500);
      settle();

      // single-sample runs, half-gram rounding at the sample extremes
      set_phase(1, 1, 2, 0, 0);
      push_sample(lcta_pkg::KIND_WEIGH, SAMPLE_MAX);
      push_sample(lcta_pkg::KIND_WEIGH, SAMPLE_MIN);
      push_sample(lcta_pkg::KIND_WEIGH, -24'sd1);
      push_sample(lcta_pkg::KIND_WEIGH, 24'sd3);
      push_sample(lcta_pkg::KIND_TARE, SAMPLE_MIN);
      push_sample(lcta_pkg::KIND_WEIGH, SAMPLE_MAX);
      push_sample(lcta_pkg::KIND_TARE, SAMPLE_MAX);
      push_sample(lcta_pkg::KIND_WEIGH, SAMPLE_MIN);
      settle();

      // zero count and zero divisor, kind change mid-run, count lowered mid-run
      set_phase(0, 3, 0, 0, 0);
      push_sample(lcta_pkg::KIND_TARE, 24'sd7);
      push_sample(lcta_pkg::KIND_TARE, -24'sd2);
      push_sample(lcta_pkg::KIND_WEIGH, 24'sd5);
      push_sample(lcta_pkg::KIND_TARE, 24'sd4);
      push_sample(lcta_pkg::KIND_TARE, -24'sd9);
      settle();
      write_reg(lcta_pkg::CSR_TARE_SAMPLES, 24'hC3C301);
      push_sample(lcta_pkg::KIND_TARE, 24'sd1);
      push_sample(lcta_pkg::KIND_WEIGH, -24'sd1);
      settle();

      set_phase(3, 5, $urandom_range(1, 4000), 0, 0);
      random_runs(250, 30);
      settle();
      set_phase(1, 2, 1, 74, 0);
      random_runs(200, 30);
      settle();
      set_phase(4, 1, 24'hFFFFFF, 0, 74);
      random_runs(200, 30);
      settle();
      set_phase(2, 3, $urandom_range(1, 4000), 16, 16);
      random_runs(250, 30);
      settle();

      // hold the output off while samples keep coming
      set_phase(1, 1, $urandom_range(1, 4000), 0, 0);
      hold_token++;
      random_runs(150, 30);
      settle();

      set_phase(255, 255, $urandom_range(1, 4000), 0, 0);
      random_runs(520, 50);
      settle();
      set_phase($urandom_range(1, 16), $urandom_range(1, 16), $urandom, 16, 16);
      random_runs(250, 30);
      settle();

      $display("Checked %0d readings from %0d samples over %0d register settings,",
               readings_seen, items_taken, phases);
      $display("covering reset, zero and extreme counts and divisors, and a long output stall.");
      if (mismatches == 0)
         $display("load_cell_tare_average_scale_tb OK");
      else
         $display("load_cell_tare_average_scale_tb NOT OK");
      $finish;
   end

endmodule

// ===== files.f =====
sv/lcta_pkg.sv
sv/lcta_fifo.sv
sv/lcta_front.sv
sv/lcta_div.sv
sv/lcta_back.sv
sv/load_cell_tare_average_scale.sv
test/load_cell_tare_average_scale_tb.sv
